[sv/bsp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsp_pkg: shared types and constants of the bit segment packer
// Beat payload structs, the queued job format and the error codes used by
// the front classifier and the back-end byte shifter.
// ----------------------------------------------------------------------------
package bsp_pkg;

  localparam int VALUE_W      = 64;
  localparam int SIZE_W       = 7;
  localparam int MAX_SEG_BITS = 64;
  localparam int HELD_W       = 7;
  localparam int HCNT_W       = 3;
  localparam int BUF_W        = VALUE_W + 8;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_RANGE   = 2'd1;
  localparam logic [1:0] ERR_LE_SIZE = 2'd2;

  typedef struct packed {
    logic signed [VALUE_W-1:0] seg_value;
    logic [SIZE_W-1:0]         seg_size;
    logic                      seg_unsigned;
    logic                      seg_little_endian;
    logic                      seg_final;
  } seg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [3:0] out_bits;
    logic       out_end;
    logic [1:0] out_error;
  } res_t;

  // One classified segment: bits left-aligned in data, size in bits.
  typedef struct packed {
    logic [VALUE_W-1:0] data;
    logic [SIZE_W-1:0]  size;
    logic               fin;
    logic [1:0]         err;
  } job_t;

endpackage

`default_nettype wire

[sv/bsp_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsp_front: segment classifier
// Checks size and range, masks the value, reorders little-endian bytes and
// left-aligns the segment bits for the back end.
// ----------------------------------------------------------------------------
module bsp_front (
  input  bsp_pkg::seg_t seg,
  output bsp_pkg::job_t job
);

  logic [bsp_pkg::VALUE_W-1:0] raw;
  logic [bsp_pkg::VALUE_W-1:0] max_u;
  logic [bsp_pkg::VALUE_W-1:0] half;
  logic [bsp_pkg::VALUE_W-1:0] u;
  logic [bsp_pkg::VALUE_W-1:0] u_be;
  logic [bsp_pkg::VALUE_W-1:0] u_le;
  logic                        ok_u;
  logic                        ok_s;
  logic                        in_range;
  logic [bsp_pkg::SIZE_W-1:0]  shamt;

  assign raw   = seg.seg_value;
  // A shift of 64 or more leaves zero, so max_u becomes all ones there.
  assign max_u = ({{(bsp_pkg::VALUE_W-1){1'b0}}, 1'b1} << seg.seg_size)
                 - {{(bsp_pkg::VALUE_W-1){1'b0}}, 1'b1};
  // For a zero size the shift count wraps high and half is zero.
  assign half  = {{(bsp_pkg::VALUE_W-1){1'b0}}, 1'b1}
                 << (seg.seg_size - bsp_pkg::SIZE_W'(1));
  assign ok_u  = (raw & ~max_u) == '0;
  assign ok_s  = ((raw + half) & ~max_u) == '0;
  assign in_range = ok_u || (!seg.seg_unsigned && ok_s);

  assign u     = raw & max_u;
  assign shamt = bsp_pkg::SIZE_W'(bsp_pkg::VALUE_W) - seg.seg_size;
  assign u_be  = u << shamt;

  // Lowest byte goes to the top; masked upper bytes land as zeros below.
  always_comb begin
    for (int k = 0; k < bsp_pkg::VALUE_W / 8; k++) begin
      u_le[bsp_pkg::VALUE_W-1-8*k -: 8] = u[8*k +: 8];
    end
  end

  always_comb begin
    job.data = seg.seg_little_endian ? u_le : u_be;
    job.size = seg.seg_size;
    job.fin  = seg.seg_final;
    if (seg.seg_size > bsp_pkg::SIZE_W'(bsp_pkg::MAX_SEG_BITS)) begin
      job.err = bsp_pkg::ERR_RANGE;
    end else if (seg.seg_little_endian && (seg.seg_size[2:0] != 3'd0)) begin
      job.err = bsp_pkg::ERR_LE_SIZE;
    end else if (!in_range) begin
      job.err = bsp_pkg::ERR_RANGE;
    end else begin
      job.err = bsp_pkg::ERR_NONE;
    end
  end

endmodule

`default_nettype wire

[sv/bsp_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsp_queue: two-entry job queue
// Decouples the segment classifier from the byte shifter.
// ----------------------------------------------------------------------------
module bsp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bsp_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          nonempty,
  output bsp_pkg::job_t head_job
);

  bsp_pkg::job_t entries [2];
  logic          head;
  logic [1:0]    count;
  logic          wr_ptr;

  assign wr_ptr   = head ^ count[0];
  assign full     = count[1];
  assign nonempty = count != 2'd0;
  assign head_job = entries[head];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (pop) begin
        head <= ~head;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/bsp_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsp_back: byte shifter
// Merges held bits with a queued segment and emits one byte per cycle while
// the result side takes it, through an output register; keeps up to seven leftover bits.
// ----------------------------------------------------------------------------
module bsp_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  input  bsp_pkg::job_t job,
  output logic          job_pop,
  output logic          res_valid,
  input  logic          res_ready,
  output bsp_pkg::res_t res
);

  logic                        active;
  logic [bsp_pkg::BUF_W-1:0]   bits_buf;
  logic [bsp_pkg::SIZE_W-1:0]  rem;
  logic                        fin;
  logic                        emitted;
  logic [1:0]                  err;
  logic [bsp_pkg::HELD_W-1:0]  held;
  logic [bsp_pkg::HCNT_W-1:0]  hcnt;
  logic                        out_free;
  logic [bsp_pkg::BUF_W-1:0]   load_buf;
  logic                        beat_load;

  assign out_free = !res_valid || res_ready;
  assign job_pop  = !active && job_valid;
  assign load_buf = {held, {(bsp_pkg::BUF_W-bsp_pkg::HELD_W){1'b0}}}
                    | ({job.data, 8'b0} >> hcnt);
  // A new beat goes into the output register this cycle.
  assign beat_load = active && out_free
                     && (err != bsp_pkg::ERR_NONE || rem >= bsp_pkg::SIZE_W'(8)
                         || (fin && (rem != '0 || !emitted)));

  always_ff @(posedge clk) begin
    if (job_pop) begin
      bits_buf <= load_buf;
      rem      <= bsp_pkg::SIZE_W'(hcnt) + job.size;
      fin      <= job.fin;
      err      <= job.err;
      emitted  <= 1'b0;
    end else if (active && out_free && err == bsp_pkg::ERR_NONE
                 && rem >= bsp_pkg::SIZE_W'(8)) begin
      bits_buf <= bits_buf << 8;
      rem      <= rem - bsp_pkg::SIZE_W'(8);
      emitted  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      held      <= '0;
      hcnt      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (beat_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (job_pop) begin
        active <= 1'b1;
      end else if (active && out_free) begin
        if (err != bsp_pkg::ERR_NONE) begin
          res.out_byte  <= 8'd0;
          res.out_bits  <= 4'd0;
          res.out_end   <= 1'b1;
          res.out_error <= err;
          held          <= '0;
          hcnt          <= '0;
          active        <= 1'b0;
        end else if (rem >= bsp_pkg::SIZE_W'(8)) begin
          res.out_byte  <= bits_buf[bsp_pkg::BUF_W-1 -: 8];
          res.out_bits  <= 4'd8;
          res.out_end   <= fin && (rem == bsp_pkg::SIZE_W'(8));
          res.out_error <= bsp_pkg::ERR_NONE;
          if (fin && (rem == bsp_pkg::SIZE_W'(8))) begin
            held   <= '0;
            hcnt   <= '0;
            active <= 1'b0;
          end
        end else if (fin) begin
          // Flush the partial byte, or an empty closing beat if none went out.
          if (rem != '0 || !emitted) begin
            res.out_byte  <= bits_buf[bsp_pkg::BUF_W-1 -: 8];
            res.out_bits  <= 4'(rem);
            res.out_end   <= 1'b1;
            res.out_error <= bsp_pkg::ERR_NONE;
          end
          held   <= '0;
          hcnt   <= '0;
          active <= 1'b0;
        end else begin
          held   <= bits_buf[bsp_pkg::BUF_W-1 -: bsp_pkg::HELD_W];
          hcnt   <= rem[bsp_pkg::HCNT_W-1:0];
          active <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

[sv/bit_segment_packer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bit_segment_packer: MSB-first bitstream packer
// Packs integer segments of 0 to 64 bits into bytes, big- or little-endian,
// flushing the partial byte on the final segment of each bitstring.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+-----------------------------
//  seg     | in        | seg_valid / seg_ready  | bsp_pkg::seg_t, one segment
//  res     | out       | res_valid / res_ready  | bsp_pkg::res_t, one byte
//
// A segment beat is classified in the cycle it is accepted and parked in a
// two-entry queue. The byte shifter then loads it, sends each full byte in
// turn, and ends with a closing step that sends the error beat, flushes the
// partial byte or keeps the leftover bits; only a final segment whose last
// byte fills exactly ends on that byte instead. The shifter takes no new
// segment from the queue until it is through with the current one.
// Reset empties the queue, drops any pending result and clears the held bits.
// A stalled result side fills the queue and then deasserts seg_ready; the
// input side keeps being taken while the queue has room.
//
module bit_segment_packer (
  input  logic          clk,
  input  logic          rst,
  input  logic          seg_valid,
  output logic          seg_ready,
  input  bsp_pkg::seg_t seg,
  output logic          res_valid,
  input  logic          res_ready,
  output bsp_pkg::res_t res
);

  bsp_pkg::job_t new_job;
  bsp_pkg::job_t head_job;
  logic          q_full;
  logic          q_nonempty;
  logic          q_pop;
  logic          q_push;

  // The queue has room: take the beat.
  assign seg_ready = !q_full;
  assign q_push    = seg_valid && seg_ready;

  // Size and range checks, masking and byte order happen up front.
  bsp_front u_front (
    .seg (seg),
    .job (new_job)
  );

  bsp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (new_job),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .head_job (head_job)
  );

  // The back end owns the leftover bits and the result register.
  bsp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_nonempty),
    .job       (head_job),
    .job_pop   (q_pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

`default_nettype wire
